// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the fall detection RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("fdt: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("fdt: next-cycle check failed");

`endif

// ===== rtl/core/fdt_pkg.sv =====
// Package for the fall detection trigger: widths, constants, types and scaling helpers.
// Depends on nothing; used by every module of the block.
package fdt_pkg;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned DIFF_W     = 17;
	localparam int unsigned SQ_W       = 2 * DIFF_W;
	localparam int unsigned SUM_W      = 32;
	localparam int unsigned RAD_A_W    = 39;
	localparam int unsigned RAD_G_W    = 45;
	localparam int unsigned RAD_W      = 46;
	localparam int unsigned ROOT_W     = RAD_W / 2;
	localparam int unsigned REM_W      = ROOT_W + 2;
	localparam int unsigned ITER_W     = $clog2(ROOT_W);
	localparam int unsigned RECIP_W    = 27;
	localparam int unsigned PROD_W     = ROOT_W + RECIP_W;
	localparam int unsigned ACC_W      = 6;
	localparam int unsigned TURN_W     = 9;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned PHASE_W    = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned NUM_AXES   = 6;
	localparam int unsigned ACC_AXES   = 3;
	localparam int unsigned AXIS_W     = $clog2(NUM_AXES);
	localparam int unsigned QDEPTH     = 2;
	localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

	// Accel level is the root shifted down; turn level is the root times a
	// rounded-up reciprocal of 13107, shifted down.
	localparam int unsigned ACC_SHIFT  = 14;
	localparam int unsigned TURN_SHIFT = 40;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [SQ_W-1:0]   sq_t;
	typedef logic [SUM_W-1:0]         sum_t;
	typedef logic [RAD_A_W-1:0]       rad_a_t;
	typedef logic [RAD_G_W-1:0]       rad_g_t;
	typedef logic [RAD_W-1:0]         rad_t;
	typedef logic [ROOT_W-1:0]        root_t;
	typedef logic [REM_W-1:0]         rem_t;
	typedef logic [ITER_W-1:0]        iter_t;
	typedef logic [RECIP_W-1:0]       recip_t;
	typedef logic [PROD_W-1:0]        prod_t;
	typedef logic [ACC_W-1:0]         acc_lvl_t;
	typedef logic [TURN_W-1:0]        turn_lvl_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [AXIS_W-1:0]        axis_t;
	typedef logic [QPTR_W-1:0]        qptr_t;
	typedef logic [QCNT_W-1:0]        qcnt_t;

	localparam diff_t OFS_AX = -diff_t'(2050);
	localparam diff_t OFS_AY = -diff_t'(77);
	localparam diff_t OFS_AZ = -diff_t'(1947);
	localparam diff_t OFS_GX = diff_t'(270);
	localparam diff_t OFS_GY = -diff_t'(351);
	localparam diff_t OFS_GZ = diff_t'(136);

	localparam recip_t TURN_RECIP = recip_t'(83887361);
	localparam iter_t  ROOT_LAST  = iter_t'(ROOT_W - 1);
	localparam axis_t  AXIS_LAST  = axis_t'(NUM_AXES - 1);
	localparam axis_t  AXIS_GYRO  = axis_t'(ACC_AXES);
	localparam qptr_t  QPTR_LAST  = qptr_t'(QDEPTH - 1);
	localparam qcnt_t  QCNT_FULL  = qcnt_t'(QDEPTH);

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE   = 3'd0,
		PH_FREE   = 3'd1,
		PH_IMPACT = 3'd2,
		PH_SETTLE = 3'd3,
		PH_FALL   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_SQUARE,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROOT,
		BK_SCALE,
		BK_STEP
	} back_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACC_LOW    = 3'd0,
		CFG_ACC_HIGH   = 3'd1,
		CFG_TURN_MIN   = 3'd2,
		CFG_TURN_MAX   = 3'd3,
		CFG_STILL_MAX  = 3'd4,
		CFG_IMPACT_WIN = 3'd5,
		CFG_TURN_WIN   = 3'd6,
		CFG_SETTLE     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		acc_lvl_t  acc_low_level;
		acc_lvl_t  acc_high_level;
		turn_lvl_t turn_min;
		turn_lvl_t turn_max;
		turn_lvl_t still_max;
		cnt_t      impact_window;
		cnt_t      turn_window;
		cnt_t      settle_wait;
	} cfg_t;

	typedef struct packed {
		rad_a_t rad_a;
		rad_g_t rad_g;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} xfer_t;

	// Multiply by 100 with shifts and adds.
	function automatic rad_a_t scale_acc(input sum_t s);
		rad_a_t w;
		begin
			w = rad_a_t'(s);
			return (w << 6) + (w << 5) + (w << 2);
		end
	endfunction

	// Multiply by 10000 with shifts and adds.
	function automatic rad_g_t scale_turn(input sum_t s);
		rad_g_t w;
		begin
			w = rad_g_t'(s);
			return (w << 13) + (w << 10) + (w << 9) + (w << 8) + (w << 4);
		end
	endfunction

endpackage

// ===== rtl/core/fdt_front.sv =====
// Front end: takes a six-axis sample, removes offsets and forms the scaled sums of squares.
// Depends on fdt_pkg; feeds fdt_queue.
module fdt_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  accel_x,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  accel_y,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  accel_z,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  gyro_x,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  gyro_y,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  gyro_z,
	output fdt_pkg::xfer_t                       push,
	input  logic                                 push_ready
);

	fdt_pkg::front_state_t state_q, state_d;
	fdt_pkg::diff_t        diff_q [fdt_pkg::NUM_AXES];
	fdt_pkg::axis_t        axis_q;
	fdt_pkg::sum_t         sum_a_q, sum_g_q;
	fdt_pkg::sq_t          sq;
	fdt_pkg::sum_t         sq_u;
	logic                  in_xfer;
	logic                  squaring;

	assign in_xfer = in_valid && in_ready;
	assign sq      = fdt_pkg::sq_t'(diff_q[0]) * fdt_pkg::sq_t'(diff_q[0]);
	assign sq_u    = sq[fdt_pkg::SUM_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdt_pkg::FR_IDLE: begin
				if (in_valid) state_d = fdt_pkg::FR_SQUARE;
			end
			fdt_pkg::FR_SQUARE: begin
				if (axis_q == fdt_pkg::AXIS_LAST) state_d = fdt_pkg::FR_PUSH;
			end
			fdt_pkg::FR_PUSH: begin
				if (push_ready) state_d = fdt_pkg::FR_IDLE;
			end
			default: state_d = fdt_pkg::FR_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == fdt_pkg::FR_IDLE);
		squaring       = (state_q == fdt_pkg::FR_SQUARE);
		push.valid     = (state_q == fdt_pkg::FR_PUSH);
		push.job.rad_a = fdt_pkg::scale_acc(sum_a_q);
		push.job.rad_g = fdt_pkg::scale_turn(sum_g_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdt_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			diff_q[0] <= fdt_pkg::diff_t'(accel_x) + fdt_pkg::OFS_AX;
			diff_q[1] <= fdt_pkg::diff_t'(accel_y) + fdt_pkg::OFS_AY;
			diff_q[2] <= fdt_pkg::diff_t'(accel_z) + fdt_pkg::OFS_AZ;
			diff_q[3] <= fdt_pkg::diff_t'(gyro_x) + fdt_pkg::OFS_GX;
			diff_q[4] <= fdt_pkg::diff_t'(gyro_y) + fdt_pkg::OFS_GY;
			diff_q[5] <= fdt_pkg::diff_t'(gyro_z) + fdt_pkg::OFS_GZ;
			axis_q    <= '0;
			sum_a_q   <= '0;
			sum_g_q   <= '0;
		end else if (squaring) begin
			for (int i = 0; i < fdt_pkg::NUM_AXES - 1; i++) begin
				diff_q[i] <= diff_q[i+1];
			end
			axis_q <= axis_q + fdt_pkg::axis_t'(1);
			if (axis_q < fdt_pkg::AXIS_GYRO) begin
				sum_a_q <= sum_a_q + sq_u;
			end else begin
				sum_g_q <= sum_g_q + sq_u;
			end
		end
	end

endmodule

// ===== rtl/core/fdt_queue.sv =====
// Short queue between the front end and the back end, holding scaled radicands.
// Depends on fdt_pkg.
module fdt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  fdt_pkg::xfer_t push,
	output logic           push_ready,
	output fdt_pkg::xfer_t pop,
	input  logic           pop_ready
);

	fdt_pkg::job_t  mem_q [fdt_pkg::QDEPTH];
	fdt_pkg::qptr_t wr_q, rd_q;
	fdt_pkg::qcnt_t cnt_q;
	logic           do_push, do_pop;

	assign push_ready = (cnt_q != fdt_pkg::QCNT_FULL);
	assign pop.valid  = (cnt_q != '0);
	assign pop.job    = mem_q[rd_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == fdt_pkg::QPTR_LAST) ? '0 : wr_q + fdt_pkg::qptr_t'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == fdt_pkg::QPTR_LAST) ? '0 : rd_q + fdt_pkg::qptr_t'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + fdt_pkg::qcnt_t'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - fdt_pkg::qcnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.job;
		end
	end

endmodule

// ===== rtl/core/fdt_back.sv =====
// Back end: bit-serial square roots, level scaling, the five-phase fall machine
// and the result register. Depends on fdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fdt_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fdt_pkg::xfer_t                  job_in,
	output logic                            job_ready,
	input  fdt_pkg::cfg_t                   cfg,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            fall_alert,
	output logic [fdt_pkg::PHASE_W-1:0]     phase,
	output logic [fdt_pkg::ACC_W-1:0]       accel_level,
	output logic [fdt_pkg::TURN_W-1:0]      turn_level
);

	typedef struct packed {
		fdt_pkg::rad_t  rad;
		fdt_pkg::rem_t  rem;
		fdt_pkg::root_t root;
	} root_state_t;

	// One restoring step: bring down two radicand bits and try a one bit.
	function automatic root_state_t root_step(input root_state_t s);
		fdt_pkg::rem_t rem_sh;
		fdt_pkg::rem_t trial;
		logic          ge;
		root_state_t   r;
		begin
			rem_sh = {s.rem[fdt_pkg::REM_W-3:0], s.rad[fdt_pkg::RAD_W-1 -: 2]};
			trial  = {s.root, 2'b01};
			ge     = (rem_sh >= trial);
			r.rad  = s.rad << 2;
			r.rem  = ge ? rem_sh - trial : rem_sh;
			r.root = {s.root[fdt_pkg::ROOT_W-2:0], ge};
			return r;
		end
	endfunction

	fdt_pkg::back_state_t bstate_q, bstate_d;
	root_state_t          ra_q, rg_q, ra_d, rg_d;
	fdt_pkg::iter_t       iter_q;
	fdt_pkg::prod_t       turn_prod_q, turn_prod_d;
	fdt_pkg::phase_t      phase_q, phase_d;
	fdt_pkg::cnt_t        cnt_q, cnt_d, cnt_inc;
	fdt_pkg::acc_lvl_t    acc_lvl;
	fdt_pkg::turn_lvl_t   turn_lvl;
	logic                 alert_d;
	logic                 job_take, rooting, scaling, step_fire;
	logic                 out_valid_q, alert_q;
	fdt_pkg::phase_t      phase_out_q;
	fdt_pkg::acc_lvl_t    acc_out_q;
	fdt_pkg::turn_lvl_t   turn_out_q;

	assign ra_d        = root_step(ra_q);
	assign rg_d        = root_step(rg_q);
	assign turn_prod_d = fdt_pkg::prod_t'(rg_q.root) * fdt_pkg::prod_t'(fdt_pkg::TURN_RECIP);
	assign acc_lvl     = ra_q.root[fdt_pkg::ACC_SHIFT +: fdt_pkg::ACC_W];
	assign turn_lvl    = turn_prod_q[fdt_pkg::TURN_SHIFT +: fdt_pkg::TURN_W];
	assign cnt_inc     = cnt_q + fdt_pkg::cnt_t'(1);

	always_comb begin
		bstate_d = bstate_q;
		case (bstate_q)
			fdt_pkg::BK_IDLE: begin
				if (job_in.valid) bstate_d = fdt_pkg::BK_ROOT;
			end
			fdt_pkg::BK_ROOT: begin
				if (iter_q == fdt_pkg::ROOT_LAST) bstate_d = fdt_pkg::BK_SCALE;
			end
			fdt_pkg::BK_SCALE: begin
				bstate_d = fdt_pkg::BK_STEP;
			end
			fdt_pkg::BK_STEP: begin
				if (!out_valid_q || out_ready) bstate_d = fdt_pkg::BK_IDLE;
			end
			default: bstate_d = fdt_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (bstate_q == fdt_pkg::BK_IDLE);
		job_take  = job_ready && job_in.valid;
		rooting   = (bstate_q == fdt_pkg::BK_ROOT);
		scaling   = (bstate_q == fdt_pkg::BK_SCALE);
		step_fire = (bstate_q == fdt_pkg::BK_STEP) && (!out_valid_q || out_ready);
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		case (phase_q)
			fdt_pkg::PH_IDLE: begin
				if (acc_lvl <= cfg.acc_low_level) phase_d = fdt_pkg::PH_FREE;
			end
			fdt_pkg::PH_FREE: begin
				cnt_d = cnt_inc;
				if (acc_lvl >= cfg.acc_high_level) begin
					cnt_d   = '0;
					phase_d = fdt_pkg::PH_IMPACT;
				end
				if (cnt_d >= cfg.impact_window) begin
					cnt_d   = '0;
					phase_d = fdt_pkg::PH_IDLE;
				end
			end
			fdt_pkg::PH_IMPACT: begin
				cnt_d = cnt_inc;
				if (turn_lvl >= cfg.turn_min && turn_lvl <= cfg.turn_max) begin
					cnt_d   = '0;
					phase_d = fdt_pkg::PH_SETTLE;
				end
				if (cnt_d >= cfg.turn_window) begin
					cnt_d   = '0;
					phase_d = fdt_pkg::PH_IDLE;
				end
			end
			fdt_pkg::PH_SETTLE: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= cfg.settle_wait) begin
					cnt_d   = '0;
					phase_d = (turn_lvl <= cfg.still_max) ? fdt_pkg::PH_FALL : fdt_pkg::PH_IDLE;
				end
			end
			fdt_pkg::PH_FALL: begin
				cnt_d   = '0;
				phase_d = fdt_pkg::PH_IDLE;
			end
			default: begin
				cnt_d   = '0;
				phase_d = fdt_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		alert_d = (phase_q == fdt_pkg::PH_FALL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q    <= fdt_pkg::BK_IDLE;
			iter_q      <= '0;
			phase_q     <= fdt_pkg::PH_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			bstate_q <= bstate_d;
			if (job_take) begin
				iter_q <= '0;
			end else if (rooting) begin
				iter_q <= iter_q + fdt_pkg::iter_t'(1);
			end
			if (step_fire) begin
				phase_q     <= phase_d;
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			ra_q.rad  <= fdt_pkg::rad_t'(job_in.job.rad_a);
			ra_q.rem  <= '0;
			ra_q.root <= '0;
			rg_q.rad  <= fdt_pkg::rad_t'(job_in.job.rad_g);
			rg_q.rem  <= '0;
			rg_q.root <= '0;
		end else if (rooting) begin
			ra_q <= ra_d;
			rg_q <= rg_d;
		end
		if (scaling) begin
			turn_prod_q <= turn_prod_d;
		end
		if (step_fire) begin
			alert_q     <= alert_d;
			phase_out_q <= phase_d;
			acc_out_q   <= acc_lvl;
			turn_out_q  <= turn_lvl;
		end
	end

	assign out_valid   = out_valid_q;
	assign fall_alert  = alert_q;
	assign phase       = phase_out_q;
	assign accel_level = acc_out_q;
	assign turn_level  = turn_out_q;

	`FDT_ASSERT_IMPL(a_cnt_clear_idle, clk, arst_n, (phase_q == fdt_pkg::PH_IDLE || phase_q == fdt_pkg::PH_FALL), (cnt_q == '0))
	`FDT_ASSERT_IMPL(a_iter_range, clk, arst_n, (bstate_q == fdt_pkg::BK_ROOT), (iter_q <= fdt_pkg::ROOT_LAST))
	`FDT_ASSERT_IMPL(a_alert_idle, clk, arst_n, (out_valid_q && alert_q), (phase_out_q == fdt_pkg::PH_IDLE))
	`FDT_ASSERT_NEXT(a_take_roots, clk, arst_n, (job_take), (bstate_q == fdt_pkg::BK_ROOT && iter_q == '0))

endmodule

// ===== rtl/core/fall_detection_trigger_fsm.sv =====
// Top level of the fall detection trigger: configuration registers and the
// front end, queue and back end. Depends on fdt_pkg, fdt_front, fdt_queue, fdt_back.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    accel_x..z, gyro_x..z (16 bit signed)
//   out      out_valid/out_ready  fall_alert, phase, accel_level, turn_level
//   cfg      cfg_valid/cfg_ready  cfg_index (3 bit), cfg_data (9 bit)
//
// A sample occupies the front end for the accept, one squaring step per axis and the
// queue transfer, and the back end for the queue transfer, 23 square root steps, one
// multiply and one result step. The bit-serial root limits the sustained rate, as the
// back end takes a new job only once it has registered the result of the last one.
// Reset clears the phase, the tick count and the queue and loads the register
// defaults; no clearing pass is needed. A two-entry queue lets the front end take
// samples while the back end is busy or its held result is not yet taken.
module fall_detection_trigger_fsm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  accel_x,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  accel_y,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  accel_z,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  gyro_x,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  gyro_y,
	input  logic signed [fdt_pkg::SAMPLE_W-1:0]  gyro_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 fall_alert,
	output logic [fdt_pkg::PHASE_W-1:0]          phase,
	output logic [fdt_pkg::ACC_W-1:0]            accel_level,
	output logic [fdt_pkg::TURN_W-1:0]           turn_level,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fdt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fdt_pkg::CFG_DATA_W-1:0]       cfg_data
);

	fdt_pkg::cfg_t  cfg_q;
	fdt_pkg::xfer_t push, pop;
	logic           push_ready, pop_ready;
	logic           cfg_xfer;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.acc_low_level  <= fdt_pkg::acc_lvl_t'(2);
			cfg_q.acc_high_level <= fdt_pkg::acc_lvl_t'(12);
			cfg_q.turn_min       <= fdt_pkg::turn_lvl_t'(30);
			cfg_q.turn_max       <= fdt_pkg::turn_lvl_t'(400);
			cfg_q.still_max      <= fdt_pkg::turn_lvl_t'(10);
			cfg_q.impact_window  <= fdt_pkg::cnt_t'(6);
			cfg_q.turn_window    <= fdt_pkg::cnt_t'(6);
			cfg_q.settle_wait    <= fdt_pkg::cnt_t'(10);
		end else if (cfg_xfer) begin
			case (fdt_pkg::cfg_idx_t'(cfg_index))
				fdt_pkg::CFG_ACC_LOW:    cfg_q.acc_low_level  <= cfg_data[fdt_pkg::ACC_W-1:0];
				fdt_pkg::CFG_ACC_HIGH:   cfg_q.acc_high_level <= cfg_data[fdt_pkg::ACC_W-1:0];
				fdt_pkg::CFG_TURN_MIN:   cfg_q.turn_min       <= cfg_data[fdt_pkg::TURN_W-1:0];
				fdt_pkg::CFG_TURN_MAX:   cfg_q.turn_max       <= cfg_data[fdt_pkg::TURN_W-1:0];
				fdt_pkg::CFG_STILL_MAX:  cfg_q.still_max      <= cfg_data[fdt_pkg::TURN_W-1:0];
				fdt_pkg::CFG_IMPACT_WIN: cfg_q.impact_window  <= cfg_data[fdt_pkg::CNT_W-1:0];
				fdt_pkg::CFG_TURN_WIN:   cfg_q.turn_window    <= cfg_data[fdt_pkg::CNT_W-1:0];
				fdt_pkg::CFG_SETTLE:     cfg_q.settle_wait    <= cfg_data[fdt_pkg::CNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	fdt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.gyro_x     (gyro_x),
		.gyro_y     (gyro_y),
		.gyro_z     (gyro_z),
		.push       (push),
		.push_ready (push_ready)
	);

	fdt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_ready  (pop_ready)
	);

	fdt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_in      (pop),
		.job_ready   (pop_ready),
		.cfg         (cfg_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fall_alert  (fall_alert),
		.phase       (phase),
		.accel_level (accel_level),
		.turn_level  (turn_level)
	);

endmodule
